// File: rtl/dcpe_pkg.sv
// Shared types and constants of the display control program executor.
// Holds the action and opcode codes, the run kind and the state, config and result records.
// No dependencies.
package dcpe_pkg;

	localparam int unsigned ADDR_W = 20;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [ADDR_W-1:0] EVEN_MASK = 20'hffffe;

	// Input actions
	localparam logic [1:0] ACT_FIELD = 2'd0;
	localparam logic [1:0] ACT_LINE  = 2'd1;
	localparam logic [1:0] ACT_PAIR  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_EN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_EN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_BUDG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INDEP_PTR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IRQ_DIS    = 3'd4;

	// Command opcodes, upper byte of the command word
	localparam logic [7:0] OP_STOP       = 8'h00;
	localparam logic [7:0] OP_NOP        = 8'h10;
	localparam logic [7:0] OP_LOAD_CP    = 8'h20;
	localparam logic [7:0] OP_LOAD_CP_ST = 8'h30;
	localparam logic [7:0] OP_LOAD_VS    = 8'h40;
	localparam logic [7:0] OP_LOAD_VS_ST = 8'h50;
	localparam logic [7:0] OP_INTERRUPT  = 8'h60;

	// Five-bit opcode classes for the border loads
	localparam logic [4:0] OP_BORDER      = 5'b01110;
	localparam logic [4:0] OP_BORDER_MODE = 5'b01111;

	// Line budgets in bytes, and the cost of one pair
	localparam logic [6:0] BUDGET_SMALL = 7'd16;
	localparam logic [6:0] BUDGET_LARGE = 7'd64;
	localparam logic [6:0] PAIR_BYTES   = 7'd4;

	typedef enum logic [1:0] {
		KIND_IDLE  = 2'd0,
		KIND_FIELD = 2'd1,
		KIND_LINE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic field_en;
		logic line_en;
		logic large_budget;
		logic indep_ptr;
		logic irq_dis;
	} dcpe_cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] video_start;
		logic [ADDR_W-1:0] control_pointer;
		logic [7:0]        border_colour;
		logic [7:0]        mode_bits;
		logic [ADDR_W-1:0] working_pointer;
		logic [ADDR_W-1:0] fetch_pointer;
		logic [6:0]        byte_budget;
		kind_t             running_kind;
		logic              first_pair;
		logic              pointer_reloaded;
	} dcpe_state_t;

	typedef struct packed {
		logic              fetch_request;
		logic [ADDR_W-1:0] fetch_address;
		logic              program_done;
		logic              irq_assert;
		logic              unknown_instruction;
	} dcpe_result_t;

endpackage

// File: rtl/dcpe_exec.sv
// Single-pass execute logic: one action or instruction pair against the program state.
// Gives the next state and the result flags and fetch address.
// Depends on dcpe_pkg.
module dcpe_exec #(
	parameter logic [19:0] FIELD_PROGRAM_BASE = 20'd512
) (
	input  dcpe_pkg::dcpe_cfg_t    cfg,
	input  dcpe_pkg::dcpe_state_t  cur,
	input  logic [1:0]             action,
	input  logic [15:0]            cmd_word,
	input  logic [15:0]            data_word,
	output dcpe_pkg::dcpe_state_t  nxt,
	output dcpe_pkg::dcpe_result_t res
);
	import dcpe_pkg::*;

	logic [ADDR_W-1:0] val;
	logic [ADDR_W-1:0] next_seq;
	logic [ADDR_W-1:0] cp_load;
	logic [ADDR_W-1:0] line_ptr;
	logic [ADDR_W-1:0] next_addr;
	logic [ADDR_W-1:0] line_end_ptr;
	logic [6:0]        budget_left;
	logic [7:0]        op;
	logic              sh_int;
	logic              sh_border;
	logic              sh_mode;
	logic              sh_unk;
	logic              stop;
	logic              field_finish;
	logic              line_finish;
	logic              chain_ptr;

	// Decode fields shared by both programs
	assign op        = cmd_word[15:8];
	assign val       = {cmd_word[3:0], data_word};
	assign next_seq  = (cur.fetch_pointer + 20'd2) & EVEN_MASK;
	assign cp_load   = {cmd_word[3:0], 8'h00, data_word[7:2], 2'b00};
	assign line_ptr  = {1'b0, cur.working_pointer[19:2], 1'b0};
	assign budget_left = (cur.byte_budget >= PAIR_BYTES) ? (cur.byte_budget - PAIR_BYTES) : 7'd0;
	assign chain_ptr = cfg.line_en & cfg.indep_ptr;

	// Classify the commands common to both programs
	assign sh_int    = (op == OP_INTERRUPT);
	assign sh_border = (cmd_word[15:11] == OP_BORDER);
	assign sh_mode   = (cmd_word[15:11] == OP_BORDER_MODE);
	assign sh_unk    = !sh_int && !sh_border && !sh_mode && !cmd_word[15];

	always_comb begin
		nxt          = cur;
		res          = '0;
		stop         = 1'b0;
		field_finish = 1'b0;
		line_finish  = 1'b0;
		next_addr    = next_seq;

		case (action)
			ACT_FIELD: begin
				nxt.running_kind     = KIND_FIELD;
				nxt.first_pair       = 1'b1;
				nxt.pointer_reloaded = 1'b0;
				if (cfg.field_en || cfg.line_en) begin
					nxt.fetch_pointer = FIELD_PROGRAM_BASE & EVEN_MASK;
					res.fetch_request = 1'b1;
					res.fetch_address = FIELD_PROGRAM_BASE & EVEN_MASK;
				end else begin
					field_finish = 1'b1;
				end
			end
			ACT_LINE: begin
				nxt.pointer_reloaded = 1'b0;
				nxt.first_pair       = 1'b0;
				if (cfg.line_en && (line_ptr != '0)) begin
					nxt.running_kind  = KIND_LINE;
					nxt.fetch_pointer = line_ptr;
					nxt.byte_budget   = cfg.large_budget ? BUDGET_LARGE : BUDGET_SMALL;
					res.fetch_request = 1'b1;
					res.fetch_address = line_ptr;
				end else begin
					nxt.running_kind  = KIND_IDLE;
					res.program_done  = 1'b1;
				end
			end
			ACT_PAIR: begin
				case (cur.running_kind)
					KIND_FIELD: begin
						nxt.first_pair = 1'b0;
						if (cur.first_pair && (cmd_word == 16'h0000)) begin
							// empty field program
							field_finish = 1'b1;
						end else begin
							case (op)
								OP_STOP: begin
									nxt.video_start = {cur.fetch_pointer[18:1], 2'b00};
									stop = 1'b1;
								end
								OP_NOP: begin
								end
								OP_LOAD_CP: begin
									nxt.control_pointer = cp_load;
								end
								OP_LOAD_CP_ST: begin
									nxt.control_pointer = cp_load;
									stop = 1'b1;
								end
								OP_LOAD_VS: begin
									next_addr = {1'b0, val[19:2], 1'b0};
								end
								OP_LOAD_VS_ST: begin
									nxt.video_start = val & EVEN_MASK;
									stop = 1'b1;
								end
								default: begin
									res.irq_assert          = sh_int & ~cfg.irq_dis;
									res.unknown_instruction = sh_unk;
									if (sh_border || sh_mode)
										nxt.border_colour = cmd_word[7:0];
									if (sh_mode)
										nxt.mode_bits = {data_word[10], data_word[6:5],
											data_word[8], data_word[3:0]};
								end
							endcase
							if (stop) begin
								field_finish = 1'b1;
							end else begin
								nxt.fetch_pointer = next_addr;
								res.fetch_request = 1'b1;
								res.fetch_address = next_addr;
							end
						end
					end
					KIND_LINE: begin
						nxt.byte_budget = budget_left;
						case (op)
							OP_STOP: begin
								stop = 1'b1;
							end
							OP_NOP: begin
							end
							OP_LOAD_CP: begin
								nxt.working_pointer = cp_load;
								nxt.control_pointer = cp_load;
								next_addr = {1'b0, cp_load[19:2], 1'b0};
							end
							OP_LOAD_CP_ST: begin
								nxt.working_pointer  = cp_load;
								nxt.control_pointer  = cp_load;
								nxt.pointer_reloaded = 1'b1;
								stop = 1'b1;
							end
							OP_LOAD_VS: begin
								nxt.video_start = val;
							end
							OP_LOAD_VS_ST: begin
								nxt.video_start = val;
								stop = 1'b1;
							end
							default: begin
								res.irq_assert          = sh_int & ~cfg.irq_dis;
								res.unknown_instruction = sh_unk;
								if (sh_border || sh_mode)
									nxt.border_colour = cmd_word[7:0];
								if (sh_mode)
									nxt.mode_bits = {data_word[10], data_word[6:5],
										data_word[8], data_word[3:0]};
							end
						endcase
						if (stop || (budget_left == 7'd0)) begin
							line_finish = 1'b1;
						end else begin
							nxt.fetch_pointer = next_addr;
							res.fetch_request = 1'b1;
							res.fetch_address = next_addr;
						end
					end
					default: begin
						// pair while idle: drop it
					end
				endcase
			end
			default: begin
				// undefined action: drop it
			end
		endcase

		// Where the line pointer lands at the end of a line run
		line_end_ptr = {next_addr[18:0], 1'b0} +
			((nxt.pointer_reloaded) ? 20'd0 : {13'd0, budget_left});

		// End a field run: line pointer from the control pointer, or zero
		if (field_finish) begin
			nxt.working_pointer = chain_ptr ? nxt.control_pointer : '0;
			nxt.running_kind    = KIND_IDLE;
			res.program_done    = 1'b1;
		end

		// End a line run: pointer where the next line carries on, or zero
		if (line_finish) begin
			nxt.working_pointer = chain_ptr ? line_end_ptr : '0;
			nxt.running_kind    = KIND_IDLE;
			res.program_done    = 1'b1;
		end
	end

endmodule

// File: rtl/display_control_program_executor_core.sv
// Display control program executor, top level: ports, configuration, pipeline registers.
// An item is held in the input stage, then its result is taken into the result register.
// Throughput: one item per cycle unless out_stall holds a full result; single-pass decode.
// A stalled full result register holds the staged item and stalls the input that cycle.
// Reset (arst_n low) clears configuration, program state and both valid flags at once.
// Depends on dcpe_pkg and dcpe_exec.
module display_control_program_executor_core #(
	parameter logic [19:0] FIELD_PROGRAM_BASE = 20'd512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write,
	input  logic [dcpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic                           cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [15:0]                    cmd_word,
	input  logic [15:0]                    data_word,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           fetch_request,
	output logic [19:0]                    fetch_address,
	output logic                           program_done,
	output logic                           irq_assert,
	output logic                           unknown_instruction,
	output logic [19:0]                    video_start_out,
	output logic [19:0]                    control_pointer_out,
	output logic [7:0]                     border_colour_out,
	output logic [7:0]                     mode_bits_out
);
	import dcpe_pkg::*;

	dcpe_cfg_t    cfg_q;
	dcpe_state_t  state_q;
	dcpe_state_t  state_nxt;
	dcpe_result_t res_nxt;
	dcpe_result_t res_q;

	logic         valid_s1;
	logic [1:0]   action_s1;
	logic [15:0]  cmd_s1;
	logic [15:0]  data_s1;
	logic         out_valid_q;
	logic         advance;

	// Execute the staged item when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FIELD_EN:   cfg_q.field_en     <= cfg_data;
				REG_LINE_EN:    cfg_q.line_en      <= cfg_data;
				REG_LARGE_BUDG: cfg_q.large_budget <= cfg_data;
				REG_INDEP_PTR:  cfg_q.indep_ptr    <= cfg_data;
				REG_IRQ_DIS:    cfg_q.irq_dis      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input stage: hold the transferred item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1 <= action;
			cmd_s1    <= cmd_word;
			data_s1   <= data_word;
		end
	end

	dcpe_exec #(
		.FIELD_PROGRAM_BASE(FIELD_PROGRAM_BASE)
	) u_exec (
		.cfg       (cfg_q),
		.cur       (state_q),
		.action    (action_s1),
		.cmd_word  (cmd_s1),
		.data_word (data_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Program state: advance with each executed item (all zero is idle)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q               <= res_nxt;
			video_start_out     <= state_nxt.video_start;
			control_pointer_out <= state_nxt.control_pointer;
			border_colour_out   <= state_nxt.border_colour;
			mode_bits_out       <= state_nxt.mode_bits;
		end
	end

	assign out_valid           = out_valid_q;
	assign fetch_request       = res_q.fetch_request;
	assign fetch_address       = res_q.fetch_address;
	assign program_done        = res_q.program_done;
	assign irq_assert          = res_q.irq_assert;
	assign unknown_instruction = res_q.unknown_instruction;

endmodule

// File: dv/testbench.sv
// Self-checking testbench for display_control_program_executor_core.
// Holds a scoreboard class that predicts each result from the transfers it sees, plus drive tasks.
// Depends on dcpe_pkg and the core RTL only.
`timescale 1ns / 100ps

import dcpe_pkg::*;

typedef struct packed {
	logic        fetch_request;
	logic [19:0] fetch_address;
	logic        program_done;
	logic        irq_assert;
	logic        unknown_instruction;
	logic [19:0] video_start;
	logic [19:0] control_pointer;
	logic [7:0]  border_colour;
	logic [7:0]  mode_bits;
} fetch_outcome_t;

class fetch_scoreboard;
	dcpe_cfg_t      regs;
	logic [19:0]    base;
	logic [19:0]    video_start, control_pointer, working_pointer, fetch_pointer;
	logic [7:0]     border_colour, mode_bits;
	logic [6:0]     byte_budget;
	kind_t          kind;
	logic           first_pair, pointer_reloaded, interrupt_flag;
	fetch_outcome_t expected_fetches[$];
	int             errors, checked;

	function new(logic [19:0] field_base);
		base             = field_base;
		regs             = '0;
		video_start      = '0;
		control_pointer  = '0;
		working_pointer  = '0;
		fetch_pointer    = '0;
		border_colour    = '0;
		mode_bits        = '0;
		byte_budget      = '0;
		kind             = KIND_IDLE;
		first_pair       = 1'b0;
		pointer_reloaded = 1'b0;
		interrupt_flag   = 1'b0;
		errors           = 0;
		checked          = 0;
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic v);
		case (idx)
		REG_FIELD_EN:   regs.field_en = v;
		REG_LINE_EN:    regs.line_en = v;
		REG_LARGE_BUDG: regs.large_budget = v;
		REG_INDEP_PTR:  regs.indep_ptr = v;
		REG_IRQ_DIS:    regs.irq_dis = v;
		default: ;
		endcase
	endfunction

	// end of a field run: the line pointer restarts from the control pointer or from zero
	function void end_field();
		working_pointer = (regs.line_en && regs.indep_ptr) ? control_pointer : '0;
		kind = KIND_IDLE;
	endfunction

	// interrupt, border loads, ignored and undefined commands, common to both programs
	function void common_op(input logic [15:0] cmd, input logic [15:0] data,
			inout fetch_outcome_t o);
		if (cmd[15:8] == OP_INTERRUPT) begin
			interrupt_flag = 1'b1;
			if (!regs.irq_dis)
				o.irq_assert = 1'b1;
		end else if (cmd[15:11] == OP_BORDER) begin
			border_colour = cmd[7:0];
		end else if (cmd[15:11] == OP_BORDER_MODE) begin
			border_colour = cmd[7:0];
			mode_bits = {data[10], data[6:5], data[8], data[3:0]};
		end else if (!cmd[15]) begin
			o.unknown_instruction = 1'b1;
		end
	endfunction

	// predict the result of one accepted input transfer
	function void note_item(logic [1:0] act, logic [15:0] cmd, logic [15:0] data);
		fetch_outcome_t o;
		logic [19:0]    val, next_addr, ptr, wp_next, cp_load;
		logic           stop;
		o = '0;
		val = {cmd[3:0], data};
		cp_load = {cmd[3:0], 8'h00, data[7:0] & 8'hfc};
		stop = 1'b0;
		if (act == ACT_FIELD) begin
			kind = KIND_FIELD;
			first_pair = 1'b1;
			pointer_reloaded = 1'b0;
			if (regs.field_en || regs.line_en) begin
				fetch_pointer = base & EVEN_MASK;
				o.fetch_request = 1'b1;
				o.fetch_address = fetch_pointer;
			end else begin
				end_field();
				o.program_done = 1'b1;
			end
		end else if (act == ACT_LINE) begin
			ptr = (working_pointer >> 1) & EVEN_MASK;
			pointer_reloaded = 1'b0;
			first_pair = 1'b0;
			if (regs.line_en && ptr != '0) begin
				kind = KIND_LINE;
				fetch_pointer = ptr;
				byte_budget = regs.large_budget ? BUDGET_LARGE : BUDGET_SMALL;
				o.fetch_request = 1'b1;
				o.fetch_address = ptr;
			end else begin
				kind = KIND_IDLE;
				o.program_done = 1'b1;
			end
		end else if (act == ACT_PAIR && kind == KIND_FIELD) begin
			if (first_pair && cmd == 16'h0000) begin
				// empty field program: the leading zero word is not executed
				first_pair = 1'b0;
				end_field();
				o.program_done = 1'b1;
			end else begin
				next_addr = (fetch_pointer + 20'd2) & EVEN_MASK;
				first_pair = 1'b0;
				case (cmd[15:8])
				OP_STOP: begin
					video_start = (next_addr - 20'd2) << 1;
					stop = 1'b1;
				end
				OP_NOP: ;
				OP_LOAD_CP: control_pointer = cp_load;
				OP_LOAD_CP_ST: begin
					control_pointer = cp_load;
					stop = 1'b1;
				end
				OP_LOAD_VS: next_addr = (val >> 1) & EVEN_MASK;
				OP_LOAD_VS_ST: begin
					next_addr = val & EVEN_MASK;
					video_start = next_addr;
					stop = 1'b1;
				end
				default: common_op(cmd, data, o);
				endcase
				if (stop) begin
					end_field();
					o.program_done = 1'b1;
				end else begin
					fetch_pointer = next_addr;
					o.fetch_request = 1'b1;
					o.fetch_address = next_addr;
				end
			end
		end else if (act == ACT_PAIR && kind == KIND_LINE) begin
			next_addr = (fetch_pointer + 20'd2) & EVEN_MASK;
			byte_budget = (byte_budget >= PAIR_BYTES) ? byte_budget - PAIR_BYTES : '0;
			case (cmd[15:8])
			OP_STOP: stop = 1'b1;
			OP_NOP: ;
			OP_LOAD_CP: begin
				working_pointer = cp_load;
				control_pointer = cp_load;
				next_addr = (cp_load >> 1) & EVEN_MASK;
			end
			OP_LOAD_CP_ST: begin
				working_pointer = cp_load;
				control_pointer = cp_load;
				pointer_reloaded = 1'b1;
				stop = 1'b1;
			end
			OP_LOAD_VS: video_start = val;
			OP_LOAD_VS_ST: begin
				video_start = val;
				stop = 1'b1;
			end
			default: common_op(cmd, data, o);
			endcase
			if (stop || byte_budget == '0) begin
				// line end: carry the pointer on, leftover budget included unless reloaded
				wp_next = next_addr << 1;
				if (!pointer_reloaded)
					wp_next = wp_next + {13'd0, byte_budget};
				working_pointer = (regs.line_en && regs.indep_ptr) ? wp_next : '0;
				kind = KIND_IDLE;
				o.program_done = 1'b1;
			end else begin
				fetch_pointer = next_addr;
				o.fetch_request = 1'b1;
				o.fetch_address = next_addr;
			end
		end
		o.video_start = video_start;
		o.control_pointer = control_pointer;
		o.border_colour = border_colour;
		o.mode_bits = mode_bits;
		expected_fetches.push_back(o);
	endfunction

	task compare_field(string name, logic [19:0] got, logic [19:0] want);
		if (got !== want)
			report($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
	endtask

	task check_result(fetch_outcome_t got);
		fetch_outcome_t want;
		if (expected_fetches.size() == 0) begin
			report("result transfer with nothing outstanding");
			return;
		end
		want = expected_fetches.pop_front();
		checked++;
		compare_field("fetch_request", 20'(got.fetch_request), 20'(want.fetch_request));
		compare_field("fetch_address", got.fetch_address, want.fetch_address);
		compare_field("program_done", 20'(got.program_done), 20'(want.program_done));
		compare_field("irq_assert", 20'(got.irq_assert), 20'(want.irq_assert));
		compare_field("unknown_instruction", 20'(got.unknown_instruction),
			20'(want.unknown_instruction));
		compare_field("video_start_out", got.video_start, want.video_start);
		compare_field("control_pointer_out", got.control_pointer, want.control_pointer);
		compare_field("border_colour_out", 20'(got.border_colour), 20'(want.border_colour));
		compare_field("mode_bits_out", 20'(got.mode_bits), 20'(want.mode_bits));
	endtask
endclass

module testbench;
	localparam logic [19:0] FIELD_BASE   = 20'd512;
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [7:0]  OP_UNDEFINED = 8'h0f;
	localparam logic [7:0]  OP_IGNORED   = 8'h81;
	localparam int          PHASES       = 8;
	localparam int          PHASE_ITEMS  = 75;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic                 cfg_data = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           action = '0;
	logic [15:0]          cmd_word = '0;
	logic [15:0]          data_word = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 fetch_request;
	logic [19:0]          fetch_address;
	logic                 program_done;
	logic                 irq_assert;
	logic                 unknown_instruction;
	logic [19:0]          video_start_out;
	logic [19:0]          control_pointer_out;
	logic [7:0]           border_colour_out;
	logic [7:0]           mode_bits_out;

	logic gap_on = 1'b0;
	logic stall_on = 1'b0;
	int   stall_left = 0;
	int   items_sent = 0;
	int   settings_used = 0;

	fetch_scoreboard board = new(FIELD_BASE);

	display_control_program_executor_core #(
		.FIELD_PROGRAM_BASE(FIELD_BASE)
	) dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_write           (cfg_write),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.action              (action),
		.cmd_word            (cmd_word),
		.data_word           (data_word),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.fetch_request       (fetch_request),
		.fetch_address       (fetch_address),
		.program_done        (program_done),
		.irq_assert          (irq_assert),
		.unknown_instruction (unknown_instruction),
		.video_start_out     (video_start_out),
		.control_pointer_out (control_pointer_out),
		.border_colour_out   (border_colour_out),
		.mode_bits_out       (mode_bits_out)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("testbench: errors");
		$finish;
	end

	// hold off the result side in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 1) begin
				stall_left <= stall_left - 1;
			end else if (stall_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(1, 9);
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	// check every result transfer against the oldest prediction
	always @(posedge clk) begin : watch_results
		fetch_outcome_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = {fetch_request, fetch_address, program_done, irq_assert,
				unknown_instruction, video_start_out, control_pointer_out,
				border_colour_out, mode_bits_out};
			board.check_result(seen);
		end
	end

	// offer one item, hold it until the transfer, then predict its result
	task automatic send_item(logic [1:0] act, logic [15:0] cmd, logic [15:0] data);
		if (gap_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		cmd_word  <= cmd;
		data_word <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!(act == ACT_UNUSED || (act == ACT_PAIR && board.kind == KIND_IDLE)))
			items_sent++;
		board.note_item(act, cmd, data);
	endtask

	// drop valid and wait for every outstanding result, then let the pipe empty
	task automatic settle();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (board.expected_fetches.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(dcpe_cfg_t c);
		logic [CFG_IDX_W-1:0] order [5];
		logic                 bits [5];
		order = '{REG_FIELD_EN, REG_LINE_EN, REG_LARGE_BUDG, REG_INDEP_PTR, REG_IRQ_DIS};
		bits = '{c.field_en, c.line_en, c.large_budget, c.indep_ptr, c.irq_dis};
		for (int i = 0; i < 5; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= bits[i];
			@(posedge clk);
			board.set_reg(order[i], bits[i]);
		end
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	// one command and data pair; a terminating one when ending is set
	function automatic logic [31:0] random_pair(bit ending);
		logic [7:0]  op;
		logic [15:0] data;
		data = 16'($urandom);
		if (ending) begin
			case ($urandom_range(0, 2))
			0: op = OP_STOP;
			1: op = OP_LOAD_CP_ST;
			default: op = OP_LOAD_VS_ST;
			endcase
		end else begin
			case ($urandom_range(0, 9))
			0: op = OP_NOP;
			1, 2: op = OP_LOAD_CP;
			3: op = OP_LOAD_VS;
			4: op = OP_INTERRUPT;
			5: op = {OP_BORDER, 3'($urandom)};
			6: op = {OP_BORDER_MODE, 3'($urandom)};
			7: op = {1'b1, 7'($urandom)};
			8: begin
				do
					op = {1'b0, 7'($urandom)};
				while (op[6:4] == 3'b111 || (op[3:0] == 4'h0 && op <= OP_INTERRUPT));
			end
			default: op = OP_NOP;
			endcase
		end
		return {op, 8'($urandom), data};
	endfunction

	// begin field, sometimes an empty program, a random body, usually a proper ending, sometimes abandoned
	task automatic run_field_program();
		logic [31:0] p;
		int          n;
		send_item(ACT_FIELD, 16'($urandom), 16'($urandom));
		if ($urandom_range(0, 14) == 0)
			send_item(ACT_PAIR, 16'h0000, 16'($urandom));
		n = $urandom_range(1, 10);
		while (board.kind == KIND_FIELD && n > 0) begin
			p = random_pair(1'b0);
			send_item(ACT_PAIR, p[31:16], p[15:0]);
			n--;
		end
		if (board.kind == KIND_FIELD && $urandom_range(0, 9) != 0) begin
			p = random_pair(1'b1);
			send_item(ACT_PAIR, p[31:16], p[15:0]);
		end
	endtask

	// begin line, then pairs until it stops, runs out of budget or gets abandoned
	task automatic run_line_program();
		logic [31:0] p;
		int          guard;
		send_item(ACT_LINE, 16'($urandom), 16'($urandom));
		guard = 0;
		while (board.kind == KIND_LINE && guard < 20) begin
			if ($urandom_range(0, 29) == 0)
				break;
			p = random_pair($urandom_range(0, 11) == 0);
			send_item(ACT_PAIR, p[31:16], p[15:0]);
			guard++;
		end
	endtask

	initial begin
		dcpe_cfg_t setting;
		int        stop_at;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// everything disabled after reset: begins end at once, pairs are ignored
		send_item(ACT_FIELD, 16'h0000, 16'h0000);
		send_item(ACT_LINE, 16'hffff, 16'hffff);
		send_item(ACT_PAIR, {OP_NOP, 8'h00}, 16'hffff);
		send_item(ACT_UNUSED, 16'hffff, 16'hffff);
		settle();
		setting = '0;
		setting.field_en = 1'b1;
		setting.line_en = 1'b1;
		setting.indep_ptr = 1'b1;
		configure(setting);

		// empty field program
		send_item(ACT_FIELD, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, 16'h0000, 16'hffff);
		// field program through every non-terminating kind of command, ending on a video start load
		send_item(ACT_FIELD, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_NOP, 8'hff}, 16'h0000);
		send_item(ACT_PAIR, {OP_LOAD_CP, 8'hbc}, 16'h12ff);
		send_item(ACT_PAIR, {OP_INTERRUPT, 8'h00}, 16'h0000);
		send_item(ACT_PAIR, {OP_BORDER, 11'h4a5}, 16'h0000);
		send_item(ACT_PAIR, {OP_BORDER_MODE, 11'h799}, 16'hffff);
		send_item(ACT_PAIR, {OP_IGNORED, 8'h23}, 16'h5555);
		send_item(ACT_PAIR, {OP_UNDEFINED, 8'h00}, 16'haaaa);
		send_item(ACT_PAIR, {OP_LOAD_VS, 8'h03}, 16'hffff);
		send_item(ACT_PAIR, {OP_LOAD_VS_ST, 8'h01}, 16'h2345);
		// line program that uses up its budget
		send_item(ACT_LINE, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_LOAD_VS, 8'h05}, 16'habcd);
		send_item(ACT_PAIR, {OP_INTERRUPT, 8'h00}, 16'h0000);
		send_item(ACT_PAIR, {OP_NOP, 8'h00}, 16'h0000);
		send_item(ACT_PAIR, {OP_NOP, 8'h00}, 16'h0000);
		// line program that jumps and then stops
		send_item(ACT_LINE, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_LOAD_CP, 8'h03}, 16'h00f0);
		send_item(ACT_PAIR, {OP_STOP, 8'h00}, 16'h0000);
		// stop on the first pair with a non-zero low byte still executes
		send_item(ACT_FIELD, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_STOP, 8'hff}, 16'h0000);
		// field abandoned by a begin line, which ends on a control pointer load
		send_item(ACT_FIELD, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_NOP, 8'h00}, 16'h0000);
		send_item(ACT_LINE, 16'h0000, 16'h0000);
		send_item(ACT_PAIR, {OP_LOAD_CP_ST, 8'h07}, 16'h0088);
		settle();

		// random programs under a series of register settings
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
			0: setting = '1;
			1: setting = '0;
			2: begin
				setting = '0;
				setting.line_en = 1'b1;
				setting.indep_ptr = 1'b1;
			end
			3: begin
				setting = '1;
				setting.line_en = 1'b0;
			end
			default: begin
				setting = dcpe_cfg_t'(5'($urandom));
				if (phase != 5) begin
					setting.line_en = 1'b1;
					setting.indep_ptr = 1'b1;
				end
			end
			endcase
			configure(setting);
			gap_on = (phase < PHASES - 1) && (phase != 4);
			stall_on = (phase < PHASES - 1) && (phase != 2);
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at) begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3: run_field_program();
				9: send_item(2'($urandom), 16'($urandom), 16'($urandom));
				default: run_line_program();
				endcase
			end
			settle();
		end

		if (board.expected_fetches.size() != 0)
			board.report($sformatf("%0d results never arrived",
				board.expected_fetches.size()));
		$display("summary: %0d items driven, %0d results compared over %0d register settings",
			items_sent, board.checked, settings_used);
		if (board.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
